// ===== rtl/core/ndg_pkg.sv =====
// Shared types and constants for the digit glyph blit sequencer.
package ndg_pkg;

  localparam int DIGIT_W     = 4;
  localparam int RECIP_SHIFT = 20;

  // floor(v * RECIP_10 / 2^20) == floor(v / 10) for every v up to 99999
  localparam logic [16:0] RECIP_10  = 17'd104858;
  localparam logic [16:0] VALUE_CAP = 17'd99999;

  localparam logic [1:0] REG_BASE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic [31:0] BASE_RST   = 32'd0;
  localparam logic [9:0]  WIDTH_RST  = 10'd16;
  localparam logic [9:0]  HEIGHT_RST = 10'd32;

  localparam logic CMD_CLEAR = 1'b0;
  localparam logic CMD_BLIT  = 1'b1;

  typedef struct packed {
    logic        draw;
    logic [2:0]  count;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [11:0] area_x;
    logic [11:0] area_y;
    logic [11:0] area_w;
    logic [11:0] area_h;
  } item_t;

  typedef struct packed {
    logic [31:0] base;
    logic [9:0]  w;
    logic [9:0]  h;
    logic [19:0] pix;
  } cfg_t;

endpackage

// ===== rtl/core/ndg_front.sv =====
// Front end: takes a request, saturates the value and splits it into decimal digits.
module ndg_front #(
  parameter int MAX_DIGITS = 5
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [16:0]                            value_i,
  input  logic [2:0]                             digit_count_i,
  input  logic [11:0]                            pos_x_i,
  input  logic [11:0]                            pos_y_i,
  input  logic [11:0]                            area_x_i,
  input  logic [11:0]                            area_y_i,
  input  logic [11:0]                            area_w_i,
  input  logic [11:0]                            area_h_i,
  output ndg_pkg::item_t                         item_o,
  output logic [MAX_DIGITS*ndg_pkg::DIGIT_W-1:0] digits_o,
  output logic                                   push_o,
  input  logic                                   full_i
);
  import ndg_pkg::*;

  localparam int IdxW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  typedef enum logic {FeIdle, FeConv} state_e;

  state_e               state_q;
  item_t                item_q;
  logic [16:0]          v_q;
  logic [2:0]           rem_q;
  logic [IdxW-1:0]      i_q;
  logic [DIGIT_W-1:0]   dig_q    [MAX_DIGITS];
  logic [DIGIT_W-1:0]   dig_push [MAX_DIGITS];

  logic [33:0]          prod;
  logic [13:0]          quot;
  logic [16:0]          quot10;
  logic [16:0]          diff;
  logic [DIGIT_W-1:0]   digit;
  logic                 last_step;
  logic                 fire;
  logic                 accept;
  logic                 draw;
  logic [16:0]          v_sat;

  // one digit per cycle (the last waits while the queue is full): reciprocal multiply, then remainder by shift-add
  assign prod   = 34'(v_q) * 34'(RECIP_10);
  assign quot   = 14'(prod >> RECIP_SHIFT);
  assign quot10 = 17'({quot, 3'b000}) + 17'({quot, 1'b0});
  assign diff   = v_q - quot10;
  assign digit  = diff[DIGIT_W-1:0];

  assign last_step = (rem_q <= 3'd1);
  assign push_o    = (state_q == FeConv) && last_step;
  assign fire      = push_o && !full_i;
  assign busy      = (state_q == FeConv) && !fire;
  assign accept    = start && !busy;

  assign draw  = (digit_count_i != 3'd0) && (32'(digit_count_i) <= MAX_DIGITS);
  assign v_sat = (value_i > VALUE_CAP) ? VALUE_CAP : value_i;

  always_comb begin
    for (int n = 0; n < MAX_DIGITS; n++) begin
      dig_push[n] = dig_q[n];
    end
    if (rem_q == 3'd1) begin
      dig_push[i_q] = digit;
    end
    for (int n = 0; n < MAX_DIGITS; n++) begin
      digits_o[n*DIGIT_W +: DIGIT_W] = dig_push[n];
    end
  end

  assign item_o = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FeIdle;
      item_q  <= '0;
      v_q     <= '0;
      rem_q   <= '0;
      i_q     <= '0;
      for (int n = 0; n < MAX_DIGITS; n++) begin
        dig_q[n] <= '0;
      end
    end else if (accept) begin
      state_q       <= FeConv;
      item_q.draw   <= draw;
      item_q.count  <= digit_count_i;
      item_q.pos_x  <= pos_x_i;
      item_q.pos_y  <= pos_y_i;
      item_q.area_x <= area_x_i;
      item_q.area_y <= area_y_i;
      item_q.area_w <= area_w_i;
      item_q.area_h <= area_h_i;
      v_q           <= v_sat;
      rem_q         <= draw ? digit_count_i : 3'd0;
      i_q           <= '0;
    end else if (state_q == FeConv) begin
      if (!last_step) begin
        dig_q[i_q] <= digit;
        v_q        <= 17'(quot);
        rem_q      <= rem_q - 3'd1;
        i_q        <= i_q + IdxW'(1);
      end else if (fire) begin
        state_q <= FeIdle;
      end
    end
  end

endmodule

// ===== rtl/core/ndg_queue.sv =====
// Two-entry queue between the digit splitter and the command generator.
module ndg_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             avail_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_q;
  logic             rd_q;
  logic [1:0]       cnt_q;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign avail_o = (cnt_q != 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && avail_o;
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) begin
        wr_q <= !wr_q;
      end
      if (do_pop) begin
        rd_q <= !rd_q;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/core/ndg_back.sv =====
// Back end: turns a queued request into a clear command and, when it draws, one blit per digit.
module ndg_back #(
  parameter int MAX_DIGITS = 5
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  ndg_pkg::cfg_t                          cfg_i,
  input  ndg_pkg::item_t                         item_i,
  input  logic [MAX_DIGITS*ndg_pkg::DIGIT_W-1:0] digits_i,
  input  logic                                   avail_i,
  output logic                                   pop_o,
  output logic                                   valid_o,
  output logic                                   command_kind_o,
  output logic [31:0]                            source_addr_o,
  output logic [12:0]                            dest_x_o,
  output logic [11:0]                            dest_y_o,
  output logic [11:0]                            rect_w_o,
  output logic [11:0]                            rect_h_o,
  output logic [19:0]                            pixel_count_o,
  output logic                                   last_o
);
  import ndg_pkg::*;

  localparam int IdxW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  item_t              cur_q;
  logic [DIGIT_W-1:0] cur_dig_q [MAX_DIGITS];
  logic               active_q;
  logic               clear_q;
  logic [IdxW-1:0]    j_q;
  logic [12:0]        x_q;

  logic               done;
  logic [DIGIT_W-1:0] digit;
  logic [23:0]        offs;
  logic [31:0]        src;

  // j_q counts down the digit positions, most significant first
  assign done  = clear_q ? !cur_q.draw : (j_q == '0);
  assign pop_o = avail_i && (!active_q || done);
  assign digit = cur_dig_q[j_q];
  assign offs  = 24'(digit) * 24'(cfg_i.pix);
  assign src   = cfg_i.base + 32'({offs, 1'b0});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      clear_q  <= 1'b0;
      valid_o  <= 1'b0;
    end else begin
      valid_o  <= active_q;
      active_q <= pop_o || (active_q && !done);
      if (pop_o) begin
        clear_q <= 1'b1;
      end else if (active_q) begin
        clear_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (active_q) begin
      if (clear_q) begin
        command_kind_o <= CMD_CLEAR;
        source_addr_o  <= '0;
        dest_x_o       <= {1'b0, cur_q.area_x};
        dest_y_o       <= cur_q.area_y;
        rect_w_o       <= cur_q.area_w;
        rect_h_o       <= cur_q.area_h;
        pixel_count_o  <= '0;
        last_o         <= !cur_q.draw;
      end else begin
        command_kind_o <= CMD_BLIT;
        source_addr_o  <= src;
        dest_x_o       <= x_q;
        dest_y_o       <= cur_q.pos_y;
        rect_w_o       <= {2'b00, cfg_i.w};
        rect_h_o       <= {2'b00, cfg_i.h};
        pixel_count_o  <= cfg_i.pix;
        last_o         <= (j_q == '0);
      end
    end
    if (pop_o) begin
      cur_q <= item_i;
      x_q   <= {1'b0, item_i.pos_x};
      j_q   <= IdxW'(item_i.count - 3'd1);
      for (int n = 0; n < MAX_DIGITS; n++) begin
        cur_dig_q[n] <= digits_i[n*DIGIT_W +: DIGIT_W];
      end
    end else if (active_q && !clear_q) begin
      x_q <= x_q + {3'b000, cfg_i.w};
      j_q <= j_q - IdxW'(1);
    end
  end

endmodule

// ===== rtl/core/number_to_digit_glyph_blits_core.sv =====
// Top level: glyph registers, digit splitter, queue and command generator.
// An item with n digits to draw gives n+1 commands, one per cycle, the first one once
// the item has passed the splitter and the queue (only a clear when only the area is cleared).
// Throughput is set by the command generator, issuing one command per cycle; the
// splitter is never the slower side.
// The receiver cannot stall. Reset empties the queue and sets base 0, 16 x 32 glyphs.
module number_to_digit_glyph_blits_core #(
  parameter int MAX_DIGITS = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        start,
  output logic        busy,
  input  logic [16:0] value_i,
  input  logic [2:0]  digit_count_i,
  input  logic [11:0] pos_x_i,
  input  logic [11:0] pos_y_i,
  input  logic [11:0] area_x_i,
  input  logic [11:0] area_y_i,
  input  logic [11:0] area_w_i,
  input  logic [11:0] area_h_i,
  output logic        valid_o,
  output logic        command_kind_o,
  output logic [31:0] source_addr_o,
  output logic [12:0] dest_x_o,
  output logic [11:0] dest_y_o,
  output logic [11:0] rect_w_o,
  output logic [11:0] rect_h_o,
  output logic [19:0] pixel_count_o,
  output logic        last_o
);
  import ndg_pkg::*;

  localparam int DigBits = MAX_DIGITS * DIGIT_W;
  localparam int QWidth  = $bits(item_t) + DigBits;

  logic [31:0]        base_q;
  logic [9:0]         w_q;
  logic [9:0]         h_q;
  logic [19:0]        pix_q;
  cfg_t               cfg;

  item_t              fe_item;
  logic [DigBits-1:0] fe_digits;
  logic               fe_push;
  logic               q_full;
  logic               q_pop;
  logic               q_avail;
  logic [QWidth-1:0]  q_rdata;
  item_t              be_item;
  logic [DigBits-1:0] be_digits;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BASE_RST;
      w_q    <= WIDTH_RST;
      h_q    <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BASE:   base_q <= cfg_wdata_i;
        REG_WIDTH:  w_q    <= cfg_wdata_i[9:0];
        REG_HEIGHT: h_q    <= cfg_wdata_i[9:0];
        default: ;
      endcase
    end
  end

  // glyph area, registered from the width and height registers
  always_ff @(posedge clk_i) begin
    pix_q <= 20'(w_q) * 20'(h_q);
  end

  assign cfg.base = base_q;
  assign cfg.w    = w_q;
  assign cfg.h    = h_q;
  assign cfg.pix  = pix_q;

  ndg_front #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_front (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .value_i,
    .digit_count_i,
    .pos_x_i,
    .pos_y_i,
    .area_x_i,
    .area_y_i,
    .area_w_i,
    .area_h_i,
    .item_o   (fe_item),
    .digits_o (fe_digits),
    .push_o   (fe_push),
    .full_i   (q_full)
  );

  ndg_queue #(
    .WIDTH(QWidth)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (fe_push),
    .wdata_i ({fe_item, fe_digits}),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .avail_o (q_avail)
  );

  assign be_item   = q_rdata[QWidth-1:DigBits];
  assign be_digits = q_rdata[DigBits-1:0];

  ndg_back #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_back (
    .clk_i,
    .rst_ni,
    .cfg_i    (cfg),
    .item_i   (be_item),
    .digits_i (be_digits),
    .avail_i  (q_avail),
    .pop_o    (q_pop),
    .valid_o,
    .command_kind_o,
    .source_addr_o,
    .dest_x_o,
    .dest_y_o,
    .rect_w_o,
    .rect_h_o,
    .pixel_count_o,
    .last_o
  );

endmodule

// ===== test/glyph_blit_checker.sv =====
// Checker for the digit glyph blit sequencer: tracks registers, predicts commands, compares.
module glyph_blit_checker
  import ndg_pkg::*;
#(
  parameter int MAX_DIGITS = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [16:0] value_i,
  input  logic [2:0]  digit_count_i,
  input  logic [11:0] pos_x_i,
  input  logic [11:0] pos_y_i,
  input  logic [11:0] area_x_i,
  input  logic [11:0] area_y_i,
  input  logic [11:0] area_w_i,
  input  logic [11:0] area_h_i,
  input  logic        valid_i,
  input  logic        command_kind_i,
  input  logic [31:0] source_addr_i,
  input  logic [12:0] dest_x_i,
  input  logic [11:0] dest_y_i,
  input  logic [11:0] rect_w_i,
  input  logic [11:0] rect_h_i,
  input  logic [19:0] pixel_count_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          outstanding_o
);

  localparam logic [16:0] SAT_VALUE = 17'd99999;

  typedef struct packed {
    logic        kind;
    logic [31:0] addr;
    logic [12:0] dx;
    logic [11:0] dy;
    logic [11:0] rw;
    logic [11:0] rh;
    logic [19:0] pix;
    logic        last;
  } blit_cmd_t;

  blit_cmd_t   pending_cmds[$];
  logic [31:0] glyph_base;
  logic [9:0]  glyph_w;
  logic [9:0]  glyph_h;

  initial fail_count_o = 0;

  task automatic check_field(input string name, input longint unsigned exp_v,
                             input longint unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  // Clear command first, then one blit per shown digit, most significant first
  task automatic queue_digit_blits(input logic [16:0] value, input logic [2:0] count,
                                   input logic [11:0] px, input logic [11:0] py,
                                   input logic [11:0] ax, input logic [11:0] ay,
                                   input logic [11:0] aw, input logic [11:0] ah);
    blit_cmd_t   cmd;
    logic [16:0] shown;
    logic [19:0] glyph_pix;
    logic        draw;
    int unsigned div;
    int unsigned digit;
    shown     = (value > SAT_VALUE) ? SAT_VALUE : value;
    draw      = (count >= 1) && (count <= MAX_DIGITS);
    glyph_pix = glyph_w * glyph_h;
    cmd       = '0;
    cmd.kind  = CMD_CLEAR;
    cmd.dx    = {1'b0, ax};
    cmd.dy    = ay;
    cmd.rw    = aw;
    cmd.rh    = ah;
    cmd.last  = !draw;
    pending_cmds.push_back(cmd);
    if (draw) begin
      for (int k = 0; k < count; k++) begin
        div = 1;
        for (int j = k + 1; j < count; j++) div *= 10;
        digit    = (shown / div) % 10;
        cmd.kind = CMD_BLIT;
        cmd.addr = glyph_base + digit * 2 * glyph_pix;
        cmd.dx   = 13'(px + k * glyph_w);
        cmd.dy   = py;
        cmd.rw   = 12'(glyph_w);
        cmd.rh   = 12'(glyph_h);
        cmd.pix  = glyph_pix;
        cmd.last = (k + 1 == count);
        pending_cmds.push_back(cmd);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    blit_cmd_t exp_cmd;
    if (!rst_ni) begin
      glyph_base = BASE_RST;
      glyph_w    = WIDTH_RST;
      glyph_h    = HEIGHT_RST;
      pending_cmds.delete();
    end else begin
      if (valid_i) begin
        if (pending_cmds.size() == 0) begin
          $error("command transfer with nothing expected");
          fail_count_o++;
        end else begin
          exp_cmd = pending_cmds.pop_front();
          check_field("command_kind", exp_cmd.kind, command_kind_i);
          check_field("source_addr", exp_cmd.addr, source_addr_i);
          check_field("dest_x", exp_cmd.dx, dest_x_i);
          check_field("dest_y", exp_cmd.dy, dest_y_i);
          check_field("rect_w", exp_cmd.rw, rect_w_i);
          check_field("rect_h", exp_cmd.rh, rect_h_i);
          check_field("pixel_count", exp_cmd.pix, pixel_count_i);
          check_field("last", exp_cmd.last, last_i);
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_BASE:   glyph_base = cfg_wdata_i;
          REG_WIDTH:  glyph_w    = cfg_wdata_i[9:0];
          REG_HEIGHT: glyph_h    = cfg_wdata_i[9:0];
          default: ;
        endcase
      end
      if (start_i && !busy_i) begin
        queue_digit_blits(value_i, digit_count_i, pos_x_i, pos_y_i,
                          area_x_i, area_y_i, area_w_i, area_h_i);
      end
    end
    outstanding_o = pending_cmds.size();
  end

endmodule

// ===== test/tb_number_to_digit_glyph_blits_core.sv =====
// Testbench top for the digit glyph blit sequencer: stimulus, register phases, verdict.
module tb_number_to_digit_glyph_blits_core;
  import ndg_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 12;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = '0;
  logic [31:0] cfg_wdata = '0;
  logic        start = 1'b0;
  logic        busy;
  logic [16:0] value = '0;
  logic [2:0]  digit_count = '0;
  logic [11:0] pos_x = '0;
  logic [11:0] pos_y = '0;
  logic [11:0] area_x = '0;
  logic [11:0] area_y = '0;
  logic [11:0] area_w = '0;
  logic [11:0] area_h = '0;
  logic        valid;
  logic        command_kind;
  logic [31:0] source_addr;
  logic [12:0] dest_x;
  logic [11:0] dest_y;
  logic [11:0] rect_w;
  logic [11:0] rect_h;
  logic [19:0] pixel_count;
  logic        last;
  int          fail_count;
  int          outstanding;
  int          quiet_cycles = 0;

  always #10 clk_i = ~clk_i;

  number_to_digit_glyph_blits_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .start         (start),
    .busy          (busy),
    .value_i       (value),
    .digit_count_i (digit_count),
    .pos_x_i       (pos_x),
    .pos_y_i       (pos_y),
    .area_x_i      (area_x),
    .area_y_i      (area_y),
    .area_w_i      (area_w),
    .area_h_i      (area_h),
    .valid_o       (valid),
    .command_kind_o(command_kind),
    .source_addr_o (source_addr),
    .dest_x_o      (dest_x),
    .dest_y_o      (dest_y),
    .rect_w_o      (rect_w),
    .rect_h_o      (rect_h),
    .pixel_count_o (pixel_count),
    .last_o        (last)
  );

  glyph_blit_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .start_i       (start),
    .busy_i        (busy),
    .value_i       (value),
    .digit_count_i (digit_count),
    .pos_x_i       (pos_x),
    .pos_y_i       (pos_y),
    .area_x_i      (area_x),
    .area_y_i      (area_y),
    .area_w_i      (area_w),
    .area_h_i      (area_h),
    .valid_i       (valid),
    .command_kind_i(command_kind),
    .source_addr_i (source_addr),
    .dest_x_i      (dest_x),
    .dest_y_i      (dest_y),
    .rect_w_i      (rect_w),
    .rect_h_i      (rect_h),
    .pixel_count_i (pixel_count),
    .last_i        (last),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  // Watchdog: cycles with neither a start transfer nor a command transfer
  always @(posedge clk_i) begin
    if ((start && !busy) || valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("number_to_digit_glyph_blits_core: mismatch");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    @(posedge clk_i);
  endtask

  // Lowers start and waits for every expected command, then lets the pipe settle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_number(input bit may_idle, input logic [16:0] v, input logic [2:0] cnt,
                             input logic [11:0] px, input logic [11:0] py,
                             input logic [11:0] ax, input logic [11:0] ay,
                             input logic [11:0] aw, input logic [11:0] ah);
    if (may_idle && $urandom_range(99) < 37) begin
      start       <= 1'b0;
      value       <= 17'($urandom);
      digit_count <= 3'($urandom);
      pos_x       <= 12'($urandom);
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    start       <= 1'b1;
    value       <= v;
    digit_count <= cnt;
    pos_x       <= px;
    pos_y       <= py;
    area_x      <= ax;
    area_y      <= ay;
    area_w      <= aw;
    area_h      <= ah;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic send_random_number(input bit may_idle);
    logic [16:0] v;
    logic [2:0]  cnt;
    v   = ($urandom_range(1) == 0) ? 17'($urandom) : 17'($urandom_range(99999));
    cnt = ($urandom_range(4) == 0) ? 3'($urandom) : 3'($urandom_range(1, 5));
    send_number(may_idle, v, cnt, 12'($urandom), 12'($urandom), 12'($urandom),
                12'($urandom), 12'($urandom), 12'($urandom));
  endtask

  task automatic random_glyph_setup();
    logic [31:0] data;
    data = $urandom;
    write_reg(REG_BASE, data);
    data = $urandom;
    if ($urandom_range(1) == 0) data[9:0] = 10'($urandom_range(4, 48));
    write_reg(REG_WIDTH, data);
    data = $urandom;
    if ($urandom_range(1) == 0) data[9:0] = 10'($urandom_range(4, 48));
    write_reg(REG_HEIGHT, data);
    if ($urandom_range(2) == 0) write_reg(REG_UNUSED, $urandom);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset glyph settings: every digit count, saturation, clear-only counts, field extremes
    send_number(1'b0, 17'd0, 3'd5, 12'd10, 12'd20, 12'd0, 12'd0, 12'd100, 12'd40);
    send_number(1'b0, 17'd9, 3'd1, 12'd1, 12'd2, 12'd3, 12'd4, 12'd5, 12'd6);
    send_number(1'b1, 17'd12345, 3'd3, 12'd100, 12'd50, 12'd90, 12'd40, 12'd80, 12'd40);
    send_number(1'b0, 17'd67890, 3'd2, 12'd7, 12'd8, 12'd9, 12'd10, 12'd11, 12'd12);
    send_number(1'b0, 17'd4321, 3'd4, 12'd300, 12'd200, 12'd1, 12'd1, 12'd1, 12'd1);
    send_number(1'b0, 17'd99999, 3'd5, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
    send_number(1'b1, 17'd100000, 3'd5, 12'd5, 12'd5, 12'd5, 12'd5, 12'd5, 12'd5);
    send_number(1'b0, 17'h1FFFF, 3'd5, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
    send_number(1'b0, 17'd54321, 3'd0, 12'd1, 12'd2, 12'd3, 12'd4, 12'd5, 12'd6);
    send_number(1'b0, 17'd54321, 3'd6, 12'd1, 12'd2, 12'd3, 12'd4, 12'd5, 12'd6);
    send_number(1'b0, 17'd54321, 3'd7, 12'd1, 12'd2, 12'd3, 12'd4, 12'd5, 12'd6);
    send_number(1'b0, 17'd0, 3'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
    drain();

    // Largest glyphs and top base address: address wraps, dest_x near 13-bit top
    write_reg(REG_BASE, 32'hFFFF_FFFF);
    write_reg(REG_WIDTH, 32'hFFFF_FFFF);
    write_reg(REG_HEIGHT, 32'hFFFF_FFFF);
    send_number(1'b0, 17'd99999, 3'd5, 12'hFFF, 12'hFFF, 12'd0, 12'd0, 12'hFFF, 12'hFFF);
    send_number(1'b0, 17'd86420, 3'd5, 12'd2048, 12'd17, 12'd1, 12'd2, 12'd3, 12'd4);
    send_number(1'b0, 17'd0, 3'd2, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
    drain();

    // Out-of-range register index must leave the settings untouched
    write_reg(REG_UNUSED, 32'h0000_0000);
    send_number(1'b0, 17'd13579, 3'd5, 12'd33, 12'd44, 12'd55, 12'd66, 12'd77, 12'd88);
    drain();

    // Zero-sized glyphs, then the smallest non-zero ones
    write_reg(REG_BASE, 32'h8000_0000);
    write_reg(REG_WIDTH, 32'h0000_0000);
    write_reg(REG_HEIGHT, 32'hFFFF_FC00);
    send_number(1'b0, 17'd24680, 3'd5, 12'd1000, 12'd1000, 12'd9, 12'd9, 12'd9, 12'd9);
    send_number(1'b0, 17'd1, 3'd1, 12'd4095, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
    drain();
    write_reg(REG_BASE, 32'h0000_0000);
    write_reg(REG_WIDTH, 32'h0000_0001);
    write_reg(REG_HEIGHT, 32'h0000_0001);
    send_number(1'b0, 17'd98765, 3'd5, 12'd4095, 12'd1, 12'd2, 12'd3, 12'd4, 12'd5);
    drain();

    // Random phases; phase 2 runs without any idling
    for (int phase = 0; phase < 5; phase++) begin
      random_glyph_setup();
      for (int n = 0; n < 54; n++) send_random_number(phase != 2);
      drain();
    end

    if (fail_count == 0 && outstanding == 0) begin
      $display("number_to_digit_glyph_blits_core: match");
    end else begin
      $display("number_to_digit_glyph_blits_core: mismatch");
    end
    $finish;
  end

endmodule

// ===== number_to_digit_glyph_blits_core.f =====
rtl/core/ndg_pkg.sv
rtl/core/ndg_front.sv
rtl/core/ndg_queue.sv
rtl/core/ndg_back.sv
rtl/core/number_to_digit_glyph_blits_core.sv
test/glyph_blit_checker.sv
test/tb_number_to_digit_glyph_blits_core.sv
